@@ hw/rtl/dtlb_pkg.sv @@
`default_nettype none

package dtlb_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_EARLY_OFFSET = 3'd0;
    localparam t_cfg_index CFG_EARLY_LINEAR = 3'd1;
    localparam t_cfg_index CFG_EARLY_SQUARE = 3'd2;
    localparam t_cfg_index CFG_LATE_OFFSET  = 3'd3;
    localparam t_cfg_index CFG_LATE_LINEAR  = 3'd4;
    localparam t_cfg_index CFG_LATE_SQUARE  = 3'd5;
    localparam t_cfg_index CFG_SLOPE        = 3'd6;
    localparam t_cfg_index CFG_CENTER       = 3'd7;

    localparam int COEF_BITS   = 32;
    localparam int SLOPE_BITS  = 24;
    localparam int CENTER_BITS = 12;

    // k = 100 per count at reset, centered on count 1440
    localparam logic signed [SLOPE_BITS-1:0] SLOPE_RESET  = 24'sd25600;
    localparam logic [CENTER_BITS-1:0]       CENTER_RESET = 12'd1440;

    // branch fixed point: offset in 2^-16, linear in 2^-24, square in 2^-40
    localparam int OFFSET_SHIFT = 8;
    localparam int SQUARE_SHIFT = 16;

    // result
    localparam int LEN_BITS        = 14;
    localparam int LEN_ROUND_SHIFT = 14;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    typedef enum logic [1:0] {
        WSEL_TABLE,
        WSEL_ZERO,
        WSEL_ONE
    } t_wsel;

    // width of a branch value in 2^-24 mm for a given count width
    function automatic int branch_bits(input int tdc_bits);
        int ltw;
        int sqs;
        int lt3w;
        ltw  = COEF_BITS + tdc_bits + 1;
        sqs  = COEF_BITS + 2 * tdc_bits - SQUARE_SHIFT;
        lt3w = ((ltw > COEF_BITS + OFFSET_SHIFT) ? ltw : COEF_BITS + OFFSET_SHIFT) + 1;
        return ((sqs > lt3w) ? sqs : lt3w) + 1;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dtlb_branch.sv @@
`default_nettype none

module dtlb_branch import dtlb_pkg::*; #(
    parameter int TDC_BITS = 12,
    localparam int BW = branch_bits(TDC_BITS)
) (
    input  logic                        i_clk,
    input  logic [TDC_BITS-1:0]         i_t,
    input  logic [2*TDC_BITS-1:0]       i_tt,
    input  logic signed [COEF_BITS-1:0] i_offset,
    input  logic signed [COEF_BITS-1:0] i_linear,
    input  logic signed [COEF_BITS-1:0] i_square,
    output logic signed [BW-1:0]        o_length
);

    localparam int LTW  = COEF_BITS + TDC_BITS + 1;
    localparam int SQW  = COEF_BITS + 2 * TDC_BITS;
    localparam int OSW  = COEF_BITS + OFFSET_SHIFT;
    localparam int LT3W = ((LTW > OSW) ? LTW : OSW) + 1;

    logic signed [LTW-1:0]  r_lin_t, n_lin_t;
    logic signed [LTW-1:0]  r_lin_t2;
    logic signed [LTW-1:0]  r_sq_lo, n_sq_lo;
    logic signed [LTW-1:0]  r_sq_hi, n_sq_hi;
    logic signed [SQW-1:0]  r_sqtt, n_sqtt;
    logic signed [LT3W-1:0] r_lt3, n_lt3;
    logic signed [BW-1:0]   r_len, n_len;

    always_comb begin
        // stage 1: linear term against the count
        n_lin_t = LTW'(i_linear) * LTW'($signed({1'b0, i_t}));
        // stage 2: square coefficient times t*t, split in two halves of t*t
        n_sq_lo = LTW'(i_square) * LTW'($signed({1'b0, i_tt[TDC_BITS-1:0]}));
        n_sq_hi = LTW'(i_square) * LTW'($signed({1'b0, i_tt[2*TDC_BITS-1:TDC_BITS]}));
        // stage 3: join halves, add offset to linear term
        n_sqtt  = (SQW'(r_sq_hi) <<< TDC_BITS) + SQW'(r_sq_lo);
        n_lt3   = LT3W'(r_lin_t2) + (LT3W'(i_offset) <<< OFFSET_SHIFT);
        // stage 4: floor of the square term plus the rest
        n_len   = BW'(r_sqtt >>> SQUARE_SHIFT) + BW'(r_lt3);
    end

    always_ff @(posedge i_clk) begin
        r_lin_t  <= n_lin_t;
        r_lin_t2 <= r_lin_t;
        r_sq_lo  <= n_sq_lo;
        r_sq_hi  <= n_sq_hi;
        r_sqtt   <= n_sqtt;
        r_lt3    <= n_lt3;
        r_len    <= n_len;
    end

    assign o_length = r_len;

endmodule

`default_nettype wire

@@ hw/rtl/drift_time_to_length_blend_top.sv @@
// Drift time to drift length converter with a logistic blend of two quadratics.
//
// Input: pulse start with a TDC count on i_tdc_count; the count is taken at any
// rising edge where start is high and busy is low. busy is only high during
// reset and until the next clock edge after reset is released, so a new
// count can be given in every cycle.
// Output: o_done is high for exactly one cycle with o_drift_length (1/1024 mm,
// saturated to 0..16383) and o_clipped. Results come out in input order,
// one per cycle at full rate. There is no output back-pressure: the receiver
// must take each result in the cycle it is shown.
// The pipeline has 10 stages: t*t, the split square products,
// two adds per branch, branch difference, magnitude, split weight products,
// their join, the signed blend and the round/saturate stage. The weight
// table is read through a two-level registered select in parallel.
// Configuration: i_cfg_we writes register i_cfg_index at the clock edge; write
// only while no transaction is in flight. Reset loads the register defaults
// and empties the pipeline.

`default_nettype none

module drift_time_to_length_blend_top import dtlb_pkg::*; #(
    parameter int TDC_BITS           = 12,
    parameter int WEIGHT_TABLE_DEPTH = 512,
    parameter int WEIGHT_BITS        = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [TDC_BITS-1:0]      i_tdc_count,
    input  logic                     i_cfg_we,
    input  t_cfg_index               i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_done,
    output logic [LEN_BITS-1:0]      o_drift_length,
    output logic                     o_clipped
);

    localparam int PIPE_STAGES = 10;
    localparam int BW          = branch_bits(TDC_BITS);
    localparam int DW          = ((TDC_BITS > CENTER_BITS) ? TDC_BITS : CENTER_BITS) + 1;
    localparam int ZW          = SLOPE_BITS + DW;
    localparam int Z_SPAN      = 4096;
    localparam int ZO_W        = $clog2(2 * Z_SPAN);
    localparam int DEPTH_W     = $clog2(WEIGHT_TABLE_DEPTH + 1);
    localparam int IP_W        = ZO_W + DEPTH_W;
    localparam int IDX_W       = $clog2(WEIGHT_TABLE_DEPTH);
    localparam int LEAF_BITS   = 5;
    localparam int GRP_W       = IDX_W - LEAF_BITS;
    localparam int GROUPS      = 1 << GRP_W;
    localparam int ROM_SIZE    = 1 << IDX_W;
    localparam int WW          = WEIGHT_BITS + 1;
    localparam int MW          = BW;
    localparam int LOW_BITS    = 26;
    localparam int MHW         = MW - LOW_BITS;
    localparam int PHW         = MHW + WW;
    localparam int PLW         = LOW_BITS + WW;
    localparam int PW          = MW + 2;
    localparam int VW          = BW + 2;
    localparam int ROUND_HALF  = 1 << (LEN_ROUND_SHIFT - 1);

    localparam logic [WW-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic [63:0]   Q30        = 64'd1 << 30;

    // ---------------- weight table, built at elaboration ----------------

    // unsigned quotient by shift and subtract, table build only
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-f in Q30 for 0 <= f <= 1, series up to the f^24 term
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = Q30;
        sum  = $signed(Q30);
        for (int j = 1; j <= 24; j++) begin
            term = udiv((term * f) >> 30, 64'(j));
            if (j[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return (sum < 0) ? 64'd0 : $unsigned(sum);
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] xq);
        logic [63:0] n;
        logic [63:0] u;
        logic [63:0] e1;
        n  = xq >> 30;
        u  = exp_neg_frac(xq & (Q30 - 64'd1));
        e1 = exp_neg_frac(Q30);
        if (n > 64'd16) begin
            n = 64'd16;
        end
        for (int k = 0; k < 16; k++) begin
            if (64'(k) < n) begin
                u = (u * e1 + (Q30 >> 1)) >> 30;
            end
        end
        return u;
    endfunction

    // entry i sits at the bin midpoint z = -16 + 32*(i+1/2)/depth
    function automatic logic [WW-1:0] weight_entry(input int i);
        logic signed [63:0] s;
        logic [63:0]        a;
        logic [63:0]        u;
        logic [63:0]        den;
        logic [63:0]        num;
        s   = 64'(32 * i + 16) - 64'(16 * WEIGHT_TABLE_DEPTH);
        a   = (s < 0) ? $unsigned(-s) : $unsigned(s);
        u   = exp_neg(udiv(a << 30, 64'(WEIGHT_TABLE_DEPTH)));
        den = Q30 + u;
        num = (s >= 0) ? u : Q30;
        return WW'(udiv((num << WEIGHT_BITS) + (den >> 1), den));
    endfunction

    logic [WW-1:0] rom [ROM_SIZE];

    for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
        localparam logic [WW-1:0] ENTRY = (gi < WEIGHT_TABLE_DEPTH) ? weight_entry(gi) : '0;
        assign rom[gi] = ENTRY;
    end

    // ---------------- configuration ----------------

    logic signed [COEF_BITS-1:0]  r_early_offset, r_early_linear, r_early_square;
    logic signed [COEF_BITS-1:0]  r_late_offset, r_late_linear, r_late_square;
    logic signed [SLOPE_BITS-1:0] r_slope;
    logic [CENTER_BITS-1:0]       r_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early_offset <= '0;
            r_early_linear <= '0;
            r_early_square <= '0;
            r_late_offset  <= '0;
            r_late_linear  <= '0;
            r_late_square  <= '0;
            r_slope        <= SLOPE_RESET;
            r_center       <= CENTER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EARLY_OFFSET: r_early_offset <= $signed(i_cfg_data);
                CFG_EARLY_LINEAR: r_early_linear <= $signed(i_cfg_data);
                CFG_EARLY_SQUARE: r_early_square <= $signed(i_cfg_data);
                CFG_LATE_OFFSET:  r_late_offset  <= $signed(i_cfg_data);
                CFG_LATE_LINEAR:  r_late_linear  <= $signed(i_cfg_data);
                CFG_LATE_SQUARE:  r_late_square  <= $signed(i_cfg_data);
                CFG_SLOPE:        r_slope        <= $signed(i_cfg_data[SLOPE_BITS-1:0]);
                CFG_CENTER:       r_center       <= i_cfg_data[CENTER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake and valid chain ----------------

    logic                   r_ready;
    logic [PIPE_STAGES-1:0] r_vld, n_vld;
    logic                   accept;

    assign busy   = ~r_ready;
    assign accept = start & r_ready;
    assign n_vld  = {r_vld[PIPE_STAGES-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_ready <= 1'b1;
            r_vld   <= n_vld;
        end
    end

    // ---------------- branches (result at stage 4) ----------------

    logic [2*TDC_BITS-1:0] r1_tt, n_tt;
    logic signed [BW-1:0]  early_len, late_len;

    assign n_tt = (2*TDC_BITS)'(i_tdc_count) * (2*TDC_BITS)'(i_tdc_count);

    dtlb_branch #(
        .TDC_BITS (TDC_BITS)
    ) u_early (
        .i_clk    (i_clk),
        .i_t      (i_tdc_count),
        .i_tt     (r1_tt),
        .i_offset (r_early_offset),
        .i_linear (r_early_linear),
        .i_square (r_early_square),
        .o_length (early_len)
    );

    dtlb_branch #(
        .TDC_BITS (TDC_BITS)
    ) u_late (
        .i_clk    (i_clk),
        .i_t      (i_tdc_count),
        .i_tt     (r1_tt),
        .i_offset (r_late_offset),
        .i_linear (r_late_linear),
        .i_square (r_late_square),
        .o_length (late_len)
    );

    // ---------------- weight path (result at stage 4) ----------------

    logic signed [DW-1:0] dt;
    logic signed [ZW-1:0] r1_z, n_z;
    t_wsel                r2_wsel, n_wsel, r3_wsel;
    logic [IDX_W-1:0]     r2_idx, n_idx;
    logic [ZO_W-1:0]      z_off;
    logic [IP_W-1:0]      idx_prod;
    logic [WW-1:0]        r3_grp [GROUPS];
    logic [WW-1:0]        n_grp [GROUPS];
    logic [GRP_W-1:0]     r3_hi;
    logic [WW-1:0]        r4_w, n_w;

    assign dt  = $signed(DW'(i_tdc_count)) - $signed(DW'(r_center));
    assign n_z = ZW'(r_slope) * ZW'(dt);

    always_comb begin
        n_wsel = WSEL_TABLE;
        priority if (r1_z >= ZW'(Z_SPAN)) begin
            n_wsel = WSEL_ZERO;
        end else if (r1_z <= ZW'(-Z_SPAN)) begin
            n_wsel = WSEL_ONE;
        end
        z_off    = ZO_W'(r1_z + ZW'(Z_SPAN));
        idx_prod = IP_W'(z_off) * IP_W'(WEIGHT_TABLE_DEPTH);
        n_idx    = IDX_W'(idx_prod >> ZO_W);
    end

    // first level picks within each group of 32, second picks the group
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g] = rom[{GRP_W'(g), r2_idx[LEAF_BITS-1:0]}];
        end
    end

    always_comb begin
        unique case (r3_wsel)
            WSEL_ZERO:  n_w = '0;
            WSEL_ONE:   n_w = WEIGHT_ONE;
            WSEL_TABLE: n_w = r3_grp[r3_hi];
            default:    n_w = '0;
        endcase
    end

    // ---------------- blend and output (stages 5 to 10) ----------------

    logic signed [BW:0]    r5_diff, n_diff;
    logic signed [BW-1:0]  r5_l, r6_l, r7_l, r8_l;
    logic [WW-1:0]         r5_w, r6_w;
    logic                  r6_neg, r7_neg, r8_neg;
    logic [MW-1:0]         r6_mag, n_mag;
    logic [PHW-1:0]        r7_phi, n_phi;
    logic [PLW-1:0]        r7_plo, n_plo;
    logic [MW-1:0]         r8_p, n_p;
    logic signed [VW-1:0]  r9_v, n_v;
    logic signed [VW:0]    rnd, scaled;
    logic [LEN_BITS-1:0]   r_len, n_len;
    logic                  r_clip, n_clip;

    always_comb begin
        n_diff = (BW+1)'(early_len) - (BW+1)'(late_len);
        n_mag  = MW'(r5_diff[BW] ? -r5_diff : r5_diff);
        // weight times magnitude, split at bit 26 of the magnitude
        n_phi  = PHW'(r6_mag[MW-1:LOW_BITS]) * PHW'(r6_w);
        n_plo  = PLW'(r6_mag[LOW_BITS-1:0]) * PLW'(r6_w);
        n_p    = MW'((PW'(r7_phi) << (LOW_BITS - WEIGHT_BITS)) + PW'(r7_plo >> WEIGHT_BITS));
        if (r8_neg) begin
            n_v = VW'(r8_l) - VW'($signed({1'b0, r8_p}));
        end else begin
            n_v = VW'(r8_l) + VW'($signed({1'b0, r8_p}));
        end
        // round half up to 2^-10 mm, then saturate
        rnd    = (VW+1)'(r9_v) + (VW+1)'(ROUND_HALF);
        scaled = rnd >>> LEN_ROUND_SHIFT;
        priority if (scaled[VW]) begin
            n_len  = '0;
            n_clip = 1'b1;
        end else if (|scaled[VW-1:LEN_BITS]) begin
            n_len  = LEN_MAX;
            n_clip = 1'b1;
        end else begin
            n_len  = scaled[LEN_BITS-1:0];
            n_clip = 1'b0;
        end
    end

    // payload registers run freely, the valid chain qualifies them
    always_ff @(posedge i_clk) begin
        r1_tt   <= n_tt;
        r1_z    <= n_z;
        r2_wsel <= n_wsel;
        r2_idx  <= n_idx;
        r3_wsel <= r2_wsel;
        r3_grp  <= n_grp;
        r3_hi   <= r2_idx[IDX_W-1:LEAF_BITS];
        r4_w    <= n_w;
        r5_diff <= n_diff;
        r5_l    <= late_len;
        r5_w    <= r4_w;
        r6_neg  <= r5_diff[BW];
        r6_mag  <= n_mag;
        r6_l    <= r5_l;
        r6_w    <= r5_w;
        r7_phi  <= n_phi;
        r7_plo  <= n_plo;
        r7_neg  <= r6_neg;
        r7_l    <= r6_l;
        r8_p    <= n_p;
        r8_neg  <= r7_neg;
        r8_l    <= r7_l;
        r9_v    <= n_v;
        r_len   <= n_len;
        r_clip  <= n_clip;
    end

    assign o_done         = r_vld[PIPE_STAGES-1];
    assign o_drift_length = r_len;
    assign o_clipped      = r_clip;

    // ---------------- assertions ----------------

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_STAGES o_done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_STAGES))
        else $error("result without a matching transaction");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r4_w <= WEIGHT_ONE))
        else $error("blend weight above one");

    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_clipped) |-> (o_drift_length == '0 || o_drift_length == LEN_MAX))
        else $error("clipped result not at a bound");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtlb_pkg::*;

    localparam int TDC_W   = 12;
    localparam int DEPTH   = 512;
    localparam int WBITS   = 16;
    localparam int LATENCY = 10;
    localparam int RANDOM_ITEMS = 750;

    typedef longint unsigned u64;
    typedef longint          s64;

    localparam u64 Q30 = u64'(1) << 30;

    typedef struct packed {
        logic [LEN_BITS-1:0] length;
        logic                clipped;
    } t_length;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PREDICT,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        t_cfg_index               index;
        logic [CFG_DATA_BITS-1:0] data;
        logic [TDC_W-1:0]         count;
        logic [LEN_BITS-1:0]      length;
        logic                     clipped;
    } t_row;

    localparam int NUM_ROWS = 47;

    // known rows: reset state, exact offsets, the four saturation edges, full weight
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd0,    14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd4095, 14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd1440, 14'd0,     1'b0},
        '{ROW_WRITE,   CFG_EARLY_OFFSET, 32'd64000,      12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_OFFSET,  32'd64000,      12'd0,    14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd2000, 14'd1000,  1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd7,    14'd1000,  1'b0},
        '{ROW_WRITE,   CFG_EARLY_OFFSET, 32'd1048512,    12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_OFFSET,  32'd1048512,    12'd0,    14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd1440, 14'd16383, 1'b0},
        '{ROW_WRITE,   CFG_EARLY_OFFSET, 32'd1048544,    12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_OFFSET,  32'd1048544,    12'd0,    14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd3,    14'd16383, 1'b1},
        '{ROW_WRITE,   CFG_EARLY_OFFSET, 32'hFFFF_FFE0,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_OFFSET,  32'hFFFF_FFE0,  12'd0,    14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd4000, 14'd0,     1'b0},
        '{ROW_WRITE,   CFG_EARLY_OFFSET, 32'hFFFF_FFDF,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_OFFSET,  32'hFFFF_FFDF,  12'd0,    14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd100,  14'd0,     1'b1},
        '{ROW_WRITE,   CFG_EARLY_OFFSET, 32'h7FFF_FFFF,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_OFFSET,  32'h8000_0000,  12'd0,    14'd0,     1'b0},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd0,    14'd16383, 1'b1},
        '{ROW_KNOWN,   CFG_EARLY_OFFSET, 32'd0,          12'd4095, 14'd0,     1'b1},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd1440, 14'd0,     1'b0},
        '{ROW_WRITE,   CFG_EARLY_LINEAR, 32'h7FFF_FFFF,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_EARLY_SQUARE, 32'h8000_0000,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_LINEAR,  32'h8000_0000,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_LATE_SQUARE,  32'h7FFF_FFFF,  12'd0,    14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd0,    14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd4095, 14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd1439, 14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd1441, 14'd0,     1'b0},
        '{ROW_WRITE,   CFG_SLOPE,        32'd0,          12'd0,    14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd100,  14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd3000, 14'd0,     1'b0},
        '{ROW_WRITE,   CFG_SLOPE,        32'h0080_0000,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_CENTER,       32'd4095,       12'd0,    14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd4095, 14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd4094, 14'd0,     1'b0},
        '{ROW_WRITE,   CFG_SLOPE,        32'h007F_FFFF,  12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_CENTER,       32'd0,          12'd0,    14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd0,    14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd1,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_SLOPE,        32'd1,          12'd0,    14'd0,     1'b0},
        '{ROW_WRITE,   CFG_CENTER,       32'd2048,       12'd0,    14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd2048, 14'd0,     1'b0},
        '{ROW_PREDICT, CFG_EARLY_OFFSET, 32'd0,          12'd4095, 14'd0,     1'b0}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [TDC_W-1:0]         i_tdc_count;
    logic                     i_cfg_we;
    t_cfg_index               i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     o_done;
    logic [LEN_BITS-1:0]      o_drift_length;
    logic                     o_clipped;

    // shadow copy of the register file
    logic signed [COEF_BITS-1:0]  early_off, early_lin, early_sq;
    logic signed [COEF_BITS-1:0]  late_off, late_lin, late_sq;
    logic signed [SLOPE_BITS-1:0] slope_k;
    logic [CENTER_BITS-1:0]       center_t0;

    u64      logistic_weight [DEPTH];
    t_length pending_lengths [$];
    int      mismatch_count = 0;

    drift_time_to_length_blend_top #(
        .TDC_BITS          (TDC_W),
        .WEIGHT_TABLE_DEPTH(DEPTH),
        .WEIGHT_BITS       (WBITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_tdc_count   (i_tdc_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_drift_length(o_drift_length),
        .o_clipped     (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    // e^-f in q30, f in q30 within 0..1, by a truncated series
    function automatic u64 exp_neg_frac(input u64 f);
        s64 acc;
        u64 term;
        acc  = s64'(Q30);
        term = Q30;
        for (int j = 1; j <= 24; j++) begin
            term = ((term * f) >> 30) / u64'(j);
            if (j % 2 == 1) acc -= s64'(term);
            else acc += s64'(term);
        end
        return (acc < 0) ? u64'(0) : u64'(acc);
    endfunction

    function automatic u64 exp_neg(input u64 xq);
        u64 whole;
        u64 u;
        u64 e1;
        whole = xq >> 30;
        u     = exp_neg_frac(xq & (Q30 - 1));
        e1    = exp_neg_frac(Q30);
        if (whole > 16) whole = 16;
        for (u64 n = 0; n < whole; n++) u = (u * e1 + (Q30 >> 1)) >> 30;
        return u;
    endfunction

    // each entry holds the weight at the midpoint of its z slice
    function automatic void build_weight_table();
        s64 s;
        u64 a, u, den, num;
        for (int i = 0; i < DEPTH; i++) begin
            s   = 32 * s64'(i) + 16 - 16 * s64'(DEPTH);
            a   = u64'((s < 0) ? -s : s);
            u   = exp_neg((a << 30) / u64'(DEPTH));
            den = Q30 + u;
            num = (s >= 0) ? u : Q30;
            logistic_weight[i] = ((num << WBITS) + den / 2) / den;
        end
    endfunction

    // branch value in 2^-24 mm
    function automatic s64 branch_value(input s64 t, input logic signed [COEF_BITS-1:0] off,
                                        input logic signed [COEF_BITS-1:0] lin,
                                        input logic signed [COEF_BITS-1:0] sq);
        return ((s64'(sq) * (t * t)) >>> SQUARE_SHIFT) + s64'(lin) * t
               + s64'(off) * (s64'(1) << OFFSET_SHIFT);
    endfunction

    function automatic t_length predict_length(input logic [TDC_W-1:0] count);
        s64      t, z, e, l, diff, v, r;
        u64      w, idx, mag, p;
        t_length res;
        t = s64'(count);
        z = s64'(slope_k) * (t - s64'(center_t0));
        if (z >= 4096) begin
            w = 0;
        end else if (z <= -4096) begin
            w = u64'(1) << WBITS;
        end else begin
            idx = u64'((z + 4096) * DEPTH) >> 13;
            if (idx >= DEPTH) idx = DEPTH - 1;
            w = logistic_weight[idx];
        end
        e    = branch_value(t, early_off, early_lin, early_sq);
        l    = branch_value(t, late_off, late_lin, late_sq);
        diff = e - l;
        mag  = u64'((diff < 0) ? -diff : diff);
        // split product, truncated toward zero
        p = (((mag >> 26) * w) << (26 - WBITS))
            + (((mag & ((u64'(1) << 26) - 1)) * w) >> WBITS);
        v = l + ((diff < 0) ? -s64'(p) : s64'(p));
        r = (v + (s64'(1) << (LEN_ROUND_SHIFT - 1))) >>> LEN_ROUND_SHIFT;
        res.clipped = 1'b0;
        if (r < 0) begin
            res.length  = '0;
            res.clipped = 1'b1;
        end else if (r > s64'(LEN_MAX)) begin
            res.length  = LEN_MAX;
            res.clipped = 1'b1;
        end else begin
            res.length = r[LEN_BITS-1:0];
        end
        return res;
    endfunction

    task automatic write_register(input t_cfg_index index, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_EARLY_OFFSET: early_off = data;
            CFG_EARLY_LINEAR: early_lin = data;
            CFG_EARLY_SQUARE: early_sq  = data;
            CFG_LATE_OFFSET:  late_off  = data;
            CFG_LATE_LINEAR:  late_lin  = data;
            CFG_LATE_SQUARE:  late_sq   = data;
            CFG_SLOPE:        slope_k   = data[SLOPE_BITS-1:0];
            CFG_CENTER:       center_t0 = data[CENTER_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_count(input logic [TDC_W-1:0] count, input logic use_known,
                              input t_length known);
        start       <= 1'b1;
        i_tdc_count <= count;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_lengths.push_back(use_known ? known : predict_length(count));
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_lengths.size() != 0);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] random_coefficient(input int span_bits);
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return $urandom;
            default: return 32'($urandom_range(0, 2 ** (span_bits + 1))) - (32'd1 << span_bits);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_slope();
        logic [SLOPE_BITS-1:0] k;
        case ($urandom_range(0, 11))
            0: k = 24'h80_0000;
            1: k = 24'h7F_FFFF;
            2: k = '0;
            3: k = 24'($urandom);
            4: k = 24'($urandom_range(1, 16));
            default: k = 24'($urandom_range(0, 2048)) - 24'd1024;
        endcase
        // bits above the register width are dropped
        return {8'($urandom), k};
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_center();
        logic [CENTER_BITS-1:0] c;
        case ($urandom_range(0, 7))
            0: c = '0;
            1: c = '1;
            default: c = 12'($urandom_range(0, 4095));
        endcase
        return {20'($urandom), c};
    endfunction

    function automatic logic [TDC_W-1:0] random_count();
        int c;
        if ($urandom_range(0, 1) == 0) return 12'($urandom_range(0, 4095));
        // cluster around the transition
        c = int'(center_t0) + int'($urandom_range(0, 128)) - 64;
        if (c < 0) c = 0;
        if (c > 4095) c = 4095;
        return 12'(c);
    endfunction

    task automatic configure_random();
        if ($urandom_range(0, 3) != 0) write_register(CFG_EARLY_OFFSET, random_coefficient(20));
        if ($urandom_range(0, 3) != 0) write_register(CFG_EARLY_LINEAR, random_coefficient(16));
        if ($urandom_range(0, 3) != 0) write_register(CFG_EARLY_SQUARE, random_coefficient(20));
        if ($urandom_range(0, 3) != 0) write_register(CFG_LATE_OFFSET,  random_coefficient(20));
        if ($urandom_range(0, 3) != 0) write_register(CFG_LATE_LINEAR,  random_coefficient(16));
        if ($urandom_range(0, 3) != 0) write_register(CFG_LATE_SQUARE,  random_coefficient(20));
        if ($urandom_range(0, 3) != 0) write_register(CFG_SLOPE,        random_slope());
        if ($urandom_range(0, 3) != 0) write_register(CFG_CENTER,       random_center());
    endtask

    // results are taken at the edge that ends their cycle
    always @(posedge i_clk) begin
        t_length want;
        if (i_rst_n === 1'b1 && o_done !== 1'b0) begin
            if (o_done !== 1'b1) begin
                $display("%0t: done strobe unknown: %b", $time, o_done);
                mismatch_count++;
            end else if (pending_lengths.size() == 0) begin
                $display("%0t: unexpected result length=%0d clipped=%b",
                         $time, o_drift_length, o_clipped);
                mismatch_count++;
            end else begin
                want = pending_lengths.pop_front();
                if (o_drift_length !== want.length) begin
                    $display("%0t: drift_length expected %0d got %0d",
                             $time, want.length, o_drift_length);
                    mismatch_count++;
                end
                if (o_clipped !== want.clipped) begin
                    $display("%0t: clipped expected %b got %b", $time, want.clipped, o_clipped);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int sent;
        int phase_len;
        int burst;
        int n;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_tdc_count = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_EARLY_OFFSET;
        i_cfg_data  = '0;
        early_off   = '0;
        early_lin   = '0;
        early_sq    = '0;
        late_off    = '0;
        late_lin    = '0;
        late_sq     = '0;
        slope_k     = SLOPE_RESET;
        center_t0   = CENTER_RESET;
        build_weight_table();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                wait_drained();
                write_register(DIRECTED[i].index, DIRECTED[i].data);
            end else begin
                send_count(DIRECTED[i].count, DIRECTED[i].kind == ROW_KNOWN,
                           t_length'{DIRECTED[i].length, DIRECTED[i].clipped});
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            configure_random();
            phase_len = $urandom_range(20, 90);
            n = 0;
            while (n < phase_len) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst && n < phase_len; b++) begin
                    send_count(random_count(), 1'b0, '0);
                    n++;
                end
                if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
            end
            sent += phase_len;
        end

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/dtlb_pkg.sv
hw/rtl/dtlb_branch.sv
hw/rtl/drift_time_to_length_blend_top.sv
tb/tb.sv
